// File: rtl/sliding_window_median_macros.svh
// Assertion macros shared by the sliding window median RTL
`ifndef SLIDING_WINDOW_MEDIAN_MACROS_SVH
`define SLIDING_WINDOW_MEDIAN_MACROS_SVH

// check a condition at every clock edge outside reset
`define SWM_ASSERT_NOW(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("sliding_window_median: invariant violated");

// check that a trigger is followed by a condition at the next edge
`define SWM_ASSERT_NEXT(label, trig, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (expr)) \
    else $error("sliding_window_median: sequence violated");

`endif

// File: rtl/swm_pkg.sv
// Shared types and fixed field widths for the sliding window median
package swm_pkg;

  localparam int IN_W  = 32;
  localparam int OUT_W = 33;
  localparam int CFG_W = 7;

  typedef struct packed {
    logic upd;
    logic remove;
  } cell_ctl_t;

endpackage

// File: rtl/swm_ram.sv
// Generic single-write, single-read RAM with registered read data
module swm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/swm_cell.sv
// One cell of the sorted window: drops the oldest value and inserts the new sample
module swm_cell #(
  parameter int SW  = 32,
  parameter int CW  = 7,
  parameter int IDX = 0
) (
  input  logic                  clk_i,
  input  swm_pkg::cell_ctl_t    ctl_i,
  input  logic [CW-1:0]         r_cnt_i,
  input  logic signed [SW-1:0]  smp_i,
  input  logic signed [SW-1:0]  old_i,
  input  logic signed [SW-1:0]  left_rval_i,
  input  logic                  left_rle_i,
  input  logic signed [SW-1:0]  right_val_i,
  output logic signed [SW-1:0]  val_o,
  output logic signed [SW-1:0]  rval_o,
  output logic                  rle_o
);
  import swm_pkg::*;

  logic signed [SW-1:0] val_q;
  logic signed [SW-1:0] val_d;
  logic signed [SW-1:0] rval;
  logic                 rle;

  always_comb begin
    if (ctl_i.remove && (val_q >= old_i)) begin
      rval = right_val_i;
    end else begin
      rval = val_q;
    end
    rle = (CW'(IDX) < r_cnt_i) && (rval <= smp_i);
    if (rle) begin
      val_d = rval;
    end else if (left_rle_i) begin
      val_d = smp_i;
    end else begin
      val_d = left_rval_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.upd) begin
      val_q <= val_d;
    end
  end

  assign val_o  = val_q;
  assign rval_o = rval;
  assign rle_o  = rle;

endmodule

// File: rtl/sliding_window_median.sv
// Sliding window median: row of sorting cells, arrival ring and output register
// Each result stays pending after its sample is accepted until the output is free.
// Throughput: one sample per cycle while not stalled; each cell updates from its two
// neighbors only, and the oldest value is read ahead from the arrival ring.
// Reset: window size 1, window empty, output empty; the stores are not cleared.
// A window size write empties the window; the first result needs window_size samples.
module sliding_window_median #(
  parameter int WINDOW_MAX   = 64,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [swm_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [swm_pkg::IN_W-1:0]   sample_i,
  input  logic                              restart_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [swm_pkg::OUT_W-1:0]  median_doubled_o
);
  import swm_pkg::*;

  localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CNT_W = $clog2(WINDOW_MAX + 1);

  logic [CNT_W-1:0]  k_q, k_d;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic [IDX_W-1:0]  oldest_q, oldest_d;
  logic              pend_q, pend_d;
  logic              out_valid_q, out_valid_d;
  logic signed [OUT_W-1:0] out_data_q;
  logic              byp_q;
  logic [SAMPLE_WIDTH-1:0] byp_val_q;

  logic              acc, res, full, move, out_free;
  logic [CNT_W-1:0]  fill_eff, r_cnt;
  logic [IDX_W-1:0]  wr_ptr;
  logic [IDX_W-1:0]  lo_idx, hi_idx;
  logic [SAMPLE_WIDTH-1:0] ram_rdata;
  logic signed [SAMPLE_WIDTH-1:0] smp, old_val;
  logic signed [SAMPLE_WIDTH:0]   med_sum;
  cell_ctl_t         ctl;

  logic signed [SAMPLE_WIDTH-1:0] cval [WINDOW_MAX];
  logic signed [SAMPLE_WIDTH-1:0] rval [WINDOW_MAX];
  logic                           rle  [WINDOW_MAX];

  assign smp      = sample_i[SAMPLE_WIDTH-1:0];
  assign out_free = !out_valid_q || !out_stall_i;
  assign move     = pend_q && out_free;
  assign in_stall_o = pend_q && !out_free;
  assign acc      = in_valid_i && !in_stall_o;

  assign fill_eff = restart_i ? '0 : fill_q;
  assign wr_ptr   = restart_i ? '0 : oldest_q;
  assign full     = (fill_eff == k_q);
  assign res      = full || (CNT_W'(fill_eff + 1'b1) == k_q);
  assign r_cnt    = full ? CNT_W'(k_q - 1'b1) : fill_eff;
  assign old_val  = byp_q ? byp_val_q : ram_rdata;

  assign ctl.upd    = acc;
  assign ctl.remove = full;

  assign lo_idx = IDX_W'((k_q - 1'b1) >> 1);
  assign hi_idx = IDX_W'(k_q >> 1);
  assign med_sum = (SAMPLE_WIDTH+1)'(cval[lo_idx]) + (SAMPLE_WIDTH+1)'(cval[hi_idx]);

  always_comb begin
    k_d         = k_q;
    fill_d      = fill_q;
    oldest_d    = oldest_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (move) begin
      out_valid_d = 1'b1;
      pend_d      = 1'b0;
    end
    if (acc) begin
      pend_d   = res;
      fill_d   = full ? k_q : CNT_W'(fill_eff + 1'b1);
      oldest_d = (wr_ptr == IDX_W'(k_q - 1'b1)) ? '0 : IDX_W'(wr_ptr + 1'b1);
    end
    if (cfg_we_i) begin
      fill_d   = '0;
      oldest_d = '0;
      if (cfg_wdata_i == '0) begin
        k_d = CNT_W'(1);
      end else if (int'(cfg_wdata_i) > WINDOW_MAX) begin
        k_d = CNT_W'(WINDOW_MAX);
      end else begin
        k_d = CNT_W'(cfg_wdata_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= CNT_W'(1);
      fill_q      <= '0;
      oldest_q    <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      byp_q       <= 1'b0;
    end else begin
      k_q         <= k_d;
      fill_q      <= fill_d;
      oldest_q    <= oldest_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      byp_q       <= acc && (wr_ptr == oldest_d);
    end
  end

  always_ff @(posedge clk_i) begin
    byp_val_q <= smp;
    if (move) begin
      out_data_q <= OUT_W'(med_sum);
    end
  end

  swm_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (acc),
    .waddr_i (wr_ptr),
    .wdata_i (smp),
    .raddr_i (oldest_d),
    .rdata_o (ram_rdata)
  );

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic signed [SAMPLE_WIDTH-1:0] left_rval;
    logic                           left_rle;
    logic signed [SAMPLE_WIDTH-1:0] right_val;

    if (i == 0) begin : g_first
      assign left_rval = '0;
      assign left_rle  = 1'b1;
    end else begin : g_mid
      assign left_rval = rval[i-1];
      assign left_rle  = rle[i-1];
    end

    if (i == WINDOW_MAX - 1) begin : g_last
      assign right_val = '0;
    end else begin : g_inner
      assign right_val = cval[i+1];
    end

    swm_cell #(
      .SW  (SAMPLE_WIDTH),
      .CW  (CNT_W),
      .IDX (i)
    ) u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .r_cnt_i     (r_cnt),
      .smp_i       (smp),
      .old_i       (old_val),
      .left_rval_i (left_rval),
      .left_rle_i  (left_rle),
      .right_val_i (right_val),
      .val_o       (cval[i]),
      .rval_o      (rval[i]),
      .rle_o       (rle[i])
    );
  end

  assign out_valid_o      = out_valid_q;
  assign median_doubled_o = out_data_q;

`include "sliding_window_median_macros.svh"

  `SWM_ASSERT_NOW(a_fill_in_window, fill_q <= k_q)
  `SWM_ASSERT_NOW(a_ptr_in_window, CNT_W'(oldest_q) < k_q)
  `SWM_ASSERT_NOW(a_stall_needs_pending, !in_stall_o || pend_q)
  `SWM_ASSERT_NEXT(a_result_pending, acc && res, pend_q)

endmodule
